@@ rtl/core/pwcd_pkg.sv @@
// ----------------------------------------------------------------------------
// pwcd_pkg
// Shared types, register indexes, reset values and window tables of the
// pulse width code decoder.
// ----------------------------------------------------------------------------
package pwcd_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int TIME_W      = 32;
   localparam int DEBOUNCE_W  = 26;
   localparam int CODE_W      = 4;
   localparam int RELAY_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 26;
   localparam int NUM_WINDOWS = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_LEVEL   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_DEBOUNCE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FALL_DEBOUNCE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECODE_ENABLE = 3'd4;

   // reset values
   localparam logic [SAMPLE_W-1:0]   THRESHOLD_RST     = 12'd2000;
   localparam logic [SAMPLE_W-1:0]   ERROR_LEVEL_RST   = 12'd1000;
   localparam logic [DEBOUNCE_W-1:0] RISE_DEBOUNCE_RST = 26'd10000;
   localparam logic [DEBOUNCE_W-1:0] FALL_DEBOUNCE_RST = 26'd10000;

   localparam logic [TIME_W-1:0]  WIDTH_OFFSET_US = 32'd10000;
   localparam logic [CODE_W-1:0]  CODE_NONE       = 4'd0;
   localparam logic [CODE_W-1:0]  CODE_MAX        = 4'd8;
   localparam logic [RELAY_W-1:0] RELAY_ALL_HIGH  = 3'b111;

   // open windows: lo < width < hi
   localparam logic [TIME_W-1:0] WIN_LO [NUM_WINDOWS] = '{
      32'd23000,  32'd48000,  32'd70000,  32'd98000,
      32'd123000, 32'd148000, 32'd173000, 32'd198000
   };
   localparam logic [TIME_W-1:0] WIN_HI [NUM_WINDOWS] = '{
      32'd30000,  32'd55000,  32'd80000,  32'd105000,
      32'd126000, 32'd155000, 32'd180000, 32'd205000
   };
   // relay pattern per code 1..8: bit0 humidifier, bit1 pump, bit2 fan
   localparam logic [RELAY_W-1:0] CODE_PATTERN [NUM_WINDOWS] = '{
      3'd7, 3'd3, 3'd6, 3'd2, 3'd7, 3'd3, 3'd6, 3'd2
   };

   typedef struct packed {
      logic [SAMPLE_W-1:0]   threshold;
      logic [SAMPLE_W-1:0]   error_level;
      logic [DEBOUNCE_W-1:0] rise_debounce_us;
      logic [DEBOUNCE_W-1:0] fall_debounce_us;
      logic                  decode_enable;
   } cfg_type;

   typedef struct packed {
      logic                alarm;
      logic [RELAY_W-1:0]  relay;
      logic [CODE_W-1:0]   code;
      logic                code_new;
   } result_type;

   // first matching window gives codes 1..8, no match gives zero
   function automatic logic [CODE_W-1:0] classify(input logic [TIME_W-1:0] width);
      logic [CODE_W-1:0] code;
      code = CODE_NONE;
      for (int i = NUM_WINDOWS - 1; i >= 0; i--) begin
         if (width > WIN_LO[i] && width < WIN_HI[i]) begin
            code = CODE_W'(i + 1);
         end
      end
      return code;
   endfunction

endpackage

@@ rtl/core/pwcd_csr.sv @@
// ----------------------------------------------------------------------------
// pwcd_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module pwcd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [pwcd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pwcd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output pwcd_pkg::cfg_type                  cfg
);

   pwcd_pkg::cfg_type cfg_ff;
   pwcd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pwcd_pkg::CSR_THRESHOLD: begin
               cfg_in.threshold = csr_wdata[pwcd_pkg::SAMPLE_W-1:0];
            end
            pwcd_pkg::CSR_ERROR_LEVEL: begin
               cfg_in.error_level = csr_wdata[pwcd_pkg::SAMPLE_W-1:0];
            end
            pwcd_pkg::CSR_RISE_DEBOUNCE: begin
               cfg_in.rise_debounce_us = csr_wdata[pwcd_pkg::DEBOUNCE_W-1:0];
            end
            pwcd_pkg::CSR_FALL_DEBOUNCE: begin
               cfg_in.fall_debounce_us = csr_wdata[pwcd_pkg::DEBOUNCE_W-1:0];
            end
            pwcd_pkg::CSR_DECODE_ENABLE: begin
               cfg_in.decode_enable = csr_wdata[0];
            end
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold        <= pwcd_pkg::THRESHOLD_RST;
         cfg_ff.error_level      <= pwcd_pkg::ERROR_LEVEL_RST;
         cfg_ff.rise_debounce_us <= pwcd_pkg::RISE_DEBOUNCE_RST;
         cfg_ff.fall_debounce_us <= pwcd_pkg::FALL_DEBOUNCE_RST;
         cfg_ff.decode_enable    <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/pwcd_track.sv @@
// ----------------------------------------------------------------------------
// pwcd_track
// Pulse tracking state and the per-sample decode step.
// ----------------------------------------------------------------------------
module pwcd_track (
   input  logic                             clock,
   input  logic                             reset,
   input  pwcd_pkg::cfg_type                cfg,
   input  logic                             step_en,
   input  logic [pwcd_pkg::SAMPLE_W-1:0]    sample,
   input  logic [pwcd_pkg::TIME_W-1:0]      time_us,
   output pwcd_pkg::result_type             result
);

   localparam int TIME_W = pwcd_pkg::TIME_W;

   logic [pwcd_pkg::TIME_W-1:0]  last_high_ff, last_high_in;
   logic [pwcd_pkg::TIME_W-1:0]  start_ff, start_in;
   logic                         closed_ff, closed_in;
   logic [pwcd_pkg::CODE_W-1:0]  code_ff, code_in;
   logic [pwcd_pkg::RELAY_W-1:0] relay_ff, relay_in;

   logic                         alarm;
   logic                         fresh;
   logic [pwcd_pkg::TIME_W-1:0]  gap;
   logic [pwcd_pkg::TIME_W-1:0]  width;
   logic [pwcd_pkg::CODE_W-1:0]  match_code;
   logic [2:0]                   pat_idx;

   assign gap        = time_us - last_high_ff;
   assign width      = time_us - start_ff - pwcd_pkg::WIDTH_OFFSET_US;
   assign match_code = pwcd_pkg::classify(width);
   assign pat_idx    = 3'(match_code - 4'd1);

   always_comb begin
      alarm        = sample < cfg.error_level;
      fresh        = 1'b0;
      last_high_in = last_high_ff;
      start_in     = start_ff;
      closed_in    = closed_ff;
      code_in      = code_ff;
      relay_in     = alarm ? pwcd_pkg::RELAY_ALL_HIGH : relay_ff;
      if (sample > cfg.threshold) begin
         if (cfg.decode_enable && gap > TIME_W'(cfg.rise_debounce_us)) begin
            start_in  = time_us;
            closed_in = 1'b0;
         end
         last_high_in = time_us;
      end else if (cfg.decode_enable && gap > TIME_W'(cfg.fall_debounce_us) &&
                   !closed_ff) begin
         closed_in = 1'b1;
         code_in   = match_code;
         fresh     = 1'b1;
         if (match_code != pwcd_pkg::CODE_NONE) begin
            relay_in = pwcd_pkg::CODE_PATTERN[pat_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_high_ff <= '0;
         start_ff     <= '0;
         closed_ff    <= 1'b0;
         code_ff      <= pwcd_pkg::CODE_NONE;
         relay_ff     <= '0;
      end else if (step_en) begin
         last_high_ff <= last_high_in;
         start_ff     <= start_in;
         closed_ff    <= closed_in;
         code_ff      <= code_in;
         relay_ff     <= relay_in;
      end
   end

   assign result.alarm    = alarm;
   assign result.relay    = relay_in;
   assign result.code     = code_in;
   assign result.code_new = fresh;

   // a close always leaves the pulse marked closed
   assert property (@(posedge clock) disable iff (reset)
      step_en && fresh |=> closed_ff)
      else $error("pulse not marked closed after decode");

   // a new pulse start reopens the pulse
   assert property (@(posedge clock) disable iff (reset)
      step_en && start_in != start_ff |=> !closed_ff)
      else $error("pulse start left pulse closed");

   // the code changes only on a close
   assert property (@(posedge clock) disable iff (reset)
      step_en && !fresh |=> code_ff == $past(code_ff))
      else $error("code changed without a close");

endmodule

@@ rtl/core/pulse_width_code_decoder_core.sv @@
// ----------------------------------------------------------------------------
// pulse_width_code_decoder_core
// Flow: an accepted request waits in the request register, passes the decode
// step and is registered in the result register once the result side is free.
// Throughput: one request per cycle while the result side accepts, set by the
// single decode step between the request register and the result register.
// Reset: synchronous; clears both valid flags, all pulse state, and loads
// the configuration registers with their default values.
// ----------------------------------------------------------------------------
module pulse_width_code_decoder_core (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pwcd_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic [pwcd_pkg::TIME_W-1:0]      req_time_us,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_alarm,
   output logic                             rsp_relay_humidifier,
   output logic                             rsp_relay_pump,
   output logic                             rsp_relay_fan,
   output logic [pwcd_pkg::CODE_W-1:0]      rsp_code,
   output logic                             rsp_code_new,
   // configuration write port
   input  logic                             csr_we,
   input  logic [pwcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pwcd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   pwcd_pkg::cfg_type    cfg;
   pwcd_pkg::result_type step_result;

   // request register
   logic                          in_valid_ff, in_valid_in;
   logic [pwcd_pkg::SAMPLE_W-1:0] in_sample_ff;
   logic [pwcd_pkg::TIME_W-1:0]   in_time_ff;

   // result register
   logic                          out_valid_ff, out_valid_in;
   pwcd_pkg::result_type          out_ff;

   logic out_free;
   logic advance;
   logic req_fire;

   // the result register can load when empty or being drained this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   // move the held request through the decode step into the result register
   assign advance   = in_valid_ff && out_free;
   // take a new request whenever the request register empties or is empty
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   pwcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // pulse state advances only when a request leaves the request register
   pwcd_track u_track (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .sample  (in_sample_ff),
      .time_us (in_time_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: hold unless loaded
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_sample_ff <= req_sample;
         in_time_ff   <= req_time_us;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_alarm            = out_ff.alarm;
   assign rsp_relay_humidifier = out_ff.relay[0];
   assign rsp_relay_pump       = out_ff.relay[1];
   assign rsp_relay_fan        = out_ff.relay[2];
   assign rsp_code             = out_ff.code;
   assign rsp_code_new         = out_ff.code_new;

   // every decode step lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("decoded request lost");

   // codes stay within 0..8
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_code <= pwcd_pkg::CODE_MAX)
      else $error("code out of range");

   // alarm without a close forces all relay lines high
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alarm && !rsp_code_new |->
         rsp_relay_humidifier && rsp_relay_pump && rsp_relay_fan)
      else $error("alarm did not force relays high");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pulse_width_code_decoder_core. Every accepted
// sample request is run through an in-bench decoder model and the expected
// alarm, relay levels and code are queued; each accepted result is compared
// field by field against the oldest entry. Stimulus mixes well-formed light
// pulses of chosen widths with random noise, across several register
// settings, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb;

   localparam int SAMPLE_W    = pwcd_pkg::SAMPLE_W;
   localparam int TIME_W      = pwcd_pkg::TIME_W;
   localparam int DEBOUNCE_W  = pwcd_pkg::DEBOUNCE_W;
   localparam int CODE_W      = pwcd_pkg::CODE_W;
   localparam int RELAY_W     = pwcd_pkg::RELAY_W;
   localparam int CSR_INDEX_W = pwcd_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = pwcd_pkg::CSR_DATA_W;
   localparam int NUM_WINDOWS = pwcd_pkg::NUM_WINDOWS;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD     = pwcd_pkg::CSR_THRESHOLD;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_LEVEL   = pwcd_pkg::CSR_ERROR_LEVEL;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_DEBOUNCE = pwcd_pkg::CSR_RISE_DEBOUNCE;
   localparam logic [CSR_INDEX_W-1:0] CSR_FALL_DEBOUNCE = pwcd_pkg::CSR_FALL_DEBOUNCE;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECODE_ENABLE = pwcd_pkg::CSR_DECODE_ENABLE;

   localparam logic [SAMPLE_W-1:0]   THRESHOLD_RST     = pwcd_pkg::THRESHOLD_RST;
   localparam logic [SAMPLE_W-1:0]   ERROR_LEVEL_RST   = pwcd_pkg::ERROR_LEVEL_RST;
   localparam logic [DEBOUNCE_W-1:0] RISE_DEBOUNCE_RST = pwcd_pkg::RISE_DEBOUNCE_RST;
   localparam logic [DEBOUNCE_W-1:0] FALL_DEBOUNCE_RST = pwcd_pkg::FALL_DEBOUNCE_RST;
   localparam logic [TIME_W-1:0]     WIDTH_OFFSET_US   = pwcd_pkg::WIDTH_OFFSET_US;
   localparam logic [CODE_W-1:0]     CODE_NONE         = pwcd_pkg::CODE_NONE;
   localparam logic [RELAY_W-1:0]    RELAY_ALL_HIGH    = pwcd_pkg::RELAY_ALL_HIGH;

   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
   localparam int unsigned DEBOUNCE_MAX = 65535000;

   // open decode windows, low < width < high, and the relay pattern per code
   localparam logic [TIME_W-1:0] WINDOW_LOW [NUM_WINDOWS] = '{
      32'd23000,  32'd48000,  32'd70000,  32'd98000,
      32'd123000, 32'd148000, 32'd173000, 32'd198000
   };
   localparam logic [TIME_W-1:0] WINDOW_HIGH [NUM_WINDOWS] = '{
      32'd30000,  32'd55000,  32'd80000,  32'd105000,
      32'd126000, 32'd155000, 32'd180000, 32'd205000
   };
   localparam logic [RELAY_W-1:0] CODE_RELAYS [NUM_WINDOWS] = '{
      3'd7, 3'd3, 3'd6, 3'd2, 3'd7, 3'd3, 3'd6, 3'd2
   };

   typedef struct packed {
      logic              alarm;
      logic              humidifier;
      logic              pump;
      logic              fan;
      logic [CODE_W-1:0] code;
      logic              code_new;
   } decode_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample;
   logic [TIME_W-1:0]      req_time_us;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_alarm;
   logic                   rsp_relay_humidifier;
   logic                   rsp_relay_pump;
   logic                   rsp_relay_fan;
   logic [CODE_W-1:0]      rsp_code;
   logic                   rsp_code_new;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // register copies and decoder state of the model
   logic [SAMPLE_W-1:0]   cfg_threshold;
   logic [SAMPLE_W-1:0]   cfg_error_level;
   logic [DEBOUNCE_W-1:0] cfg_rise;
   logic [DEBOUNCE_W-1:0] cfg_fall;
   logic                  cfg_decode_en;
   logic [TIME_W-1:0]     last_high_us;
   logic [TIME_W-1:0]     pulse_start_us;
   logic                  pulse_done;
   logic [CODE_W-1:0]     held_code;
   logic [RELAY_W-1:0]    relay_levels;

   decode_type        expected_decodes[$];
   logic [TIME_W-1:0] stim_time;
   int                sent_items;
   int                result_count;
   int                mismatch_count;
   bit                idle_on;
   int                idle_pct;
   int                stall_left;

   pulse_width_code_decoder_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_sample           (req_sample),
      .req_time_us          (req_time_us),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_alarm            (rsp_alarm),
      .rsp_relay_humidifier (rsp_relay_humidifier),
      .rsp_relay_pump       (rsp_relay_pump),
      .rsp_relay_fan        (rsp_relay_fan),
      .rsp_code             (rsp_code),
      .rsp_code_new         (rsp_code_new),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: end the run if the handshakes stop moving.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   // Advance the decoder model by one sample and return what the block
   // must answer for it.
   function automatic decode_type predict_decode(input logic [SAMPLE_W-1:0] sample,
                                                 input logic [TIME_W-1:0] t);
      decode_type        r;
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] width;
      r = '0;
      // the alarm forces all relay lines high before any decode
      if (sample < cfg_error_level) begin
         r.alarm = 1'b1;
         relay_levels = RELAY_ALL_HIGH;
      end
      gap = t - last_high_us;
      if (sample > cfg_threshold) begin
         // a long enough dark gap restarts the pulse
         if (cfg_decode_en && gap > TIME_W'(cfg_rise)) begin
            pulse_start_us = t;
            pulse_done = 1'b0;
         end
         last_high_us = t;
      end else if (cfg_decode_en && gap > TIME_W'(cfg_fall) && !pulse_done) begin
         // close the pulse and classify its width, first window wins
         width = t - pulse_start_us - WIDTH_OFFSET_US;
         pulse_done = 1'b1;
         held_code = CODE_NONE;
         for (int k = 0; k < NUM_WINDOWS; k++) begin
            if (held_code == CODE_NONE && width > WINDOW_LOW[k] && width < WINDOW_HIGH[k]) begin
               held_code = CODE_W'(k + 1);
            end
         end
         // no match leaves the relays as they are
         if (held_code != CODE_NONE) begin
            relay_levels = CODE_RELAYS[3'(held_code - 1)];
         end
         r.code_new = 1'b1;
      end
      r.humidifier = relay_levels[0];
      r.pump       = relay_levels[1];
      r.fan        = relay_levels[2];
      r.code       = held_code;
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_high();
      if (cfg_threshold == SAMPLE_W'(SAMPLE_MAX)) begin
         return SAMPLE_W'(SAMPLE_MAX);
      end
      return SAMPLE_W'($urandom_range(int'(cfg_threshold) + 1, SAMPLE_MAX));
   endfunction

   // Mostly dark but above the error level; now and then dip into the alarm.
   function automatic logic [SAMPLE_W-1:0] pick_low();
      int unsigned floor_lvl;
      if ($urandom_range(0, 5) == 0) begin
         return SAMPLE_W'($urandom_range(0, cfg_threshold));
      end
      floor_lvl = (cfg_error_level < cfg_threshold) ? cfg_error_level : cfg_threshold;
      return SAMPLE_W'($urandom_range(floor_lvl, cfg_threshold));
   endfunction

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch at result %0d: %s got %0d expected %0d",
               result_count, field, got, want);
      mismatch_count++;
   endtask

   // Present one sample request, hold it until accepted, queue its expected
   // result, then maybe drop valid for an idle burst.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample,
                              input logic [TIME_W-1:0] t);
      req_valid   <= 1'b1;
      req_sample  <= sample;
      req_time_us <= t;
      do @(posedge clock); while (!req_ready);
      expected_decodes.push_back(predict_decode(sample, t));
      sent_items++;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   // Drop valid and wait until every queued result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_decodes.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_THRESHOLD:     cfg_threshold   = value[SAMPLE_W-1:0];
         CSR_ERROR_LEVEL:   cfg_error_level = value[SAMPLE_W-1:0];
         CSR_RISE_DEBOUNCE: cfg_rise        = value[DEBOUNCE_W-1:0];
         CSR_FALL_DEBOUNCE: cfg_fall        = value[DEBOUNCE_W-1:0];
         CSR_DECODE_ENABLE: cfg_decode_en   = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Load every register, with junk above its width where the bus is wider, plus
   // one write to an unused index, all while the block is idle.
   task automatic apply_settings(input logic [SAMPLE_W-1:0] th, input logic [SAMPLE_W-1:0] err,
                                 input logic [DEBOUNCE_W-1:0] rise,
                                 input logic [DEBOUNCE_W-1:0] fall, input logic en);
      logic [CSR_DATA_W-1:0] wdata;
      wait_for_drain();
      wdata = CSR_DATA_W'($urandom());
      wdata[SAMPLE_W-1:0] = th;
      write_csr(CSR_THRESHOLD, wdata);
      wdata = CSR_DATA_W'($urandom());
      wdata[SAMPLE_W-1:0] = err;
      write_csr(CSR_ERROR_LEVEL, wdata);
      write_csr(CSR_RISE_DEBOUNCE, rise);
      write_csr(CSR_FALL_DEBOUNCE, fall);
      wdata = CSR_DATA_W'($urandom());
      wdata[0] = en;
      write_csr(CSR_DECODE_ENABLE, wdata);
      write_csr(CSR_INDEX_W'(CSR_DECODE_ENABLE + 1 + $urandom_range(0, 2)),
                CSR_DATA_W'($urandom()));
      csr_we <= 1'b0;
   endtask

   // Build one light pulse: a rising sample after a long dark gap, a few
   // more lit samples, some dark samples inside the fall debounce, then the
   // closing sample placed so the width lands where it was aimed.
   task automatic send_pulse();
      logic [TIME_W-1:0] width;
      logic [TIME_W-1:0] t0;
      logic [TIME_W-1:0] t_high;
      logic [TIME_W-1:0] t_at;
      logic [TIME_W-1:0] t_close;
      longint            room;
      int unsigned       win;
      int unsigned       pick;
      win  = $urandom_range(0, NUM_WINDOWS - 1);
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         width = WINDOW_LOW[win] + 1 +
                 $urandom_range(0, WINDOW_HIGH[win] - WINDOW_LOW[win] - 2);
      end else if (pick == 6) begin
         width = $urandom_range(0, 1) ? WINDOW_LOW[win] : WINDOW_HIGH[win];
      end else if (pick == 7) begin
         width = $urandom_range(0, 1) ? WINDOW_LOW[win] + 1 : WINDOW_HIGH[win] - 1;
      end else if (pick == 8) begin
         width = $urandom_range(0, 220000);
      end else begin
         width = $urandom();
      end
      t0      = stim_time + TIME_W'(cfg_rise) + 1 + $urandom_range(0, 3000);
      t_close = t0 + width + WIDTH_OFFSET_US;
      room    = longint'(width) + longint'(WIDTH_OFFSET_US) - longint'(cfg_fall) - 1;
      t_high  = t0;
      if (room > 0) begin
         t_high = t0 + $urandom_range(0, (room < 4000) ? room : 4000);
      end
      send_sample(pick_high(), t0);
      t_at = t0;
      repeat ($urandom_range(0, 2)) begin
         t_at = t_at + $urandom_range(0, t_high - t_at);
         send_sample(pick_high(), t_at);
      end
      if (t_high != t_at) begin
         send_sample(pick_high(), t_high);
      end
      // dark samples that stay within the fall debounce must not close
      if (cfg_fall != 0) begin
         repeat ($urandom_range(0, 2)) begin
            send_sample(pick_low(), t_high + $urandom_range(1, cfg_fall));
         end
      end
      // the fall debounce is longer than the aimed width: close when it allows
      if (room < 0) begin
         t_close = t_high + TIME_W'(cfg_fall) + 1 + $urandom_range(0, 2000);
      end
      send_sample(pick_low(), t_close);
      stim_time = t_close;
      if ($urandom_range(0, 1) == 1) begin
         stim_time = t_close + $urandom_range(0, 50000);
         send_sample(pick_low(), stim_time);
      end
   endtask

   task automatic send_noise();
      if ($urandom_range(0, 3) == 0) begin
         stim_time = $urandom();
      end else begin
         stim_time = stim_time + $urandom_range(0, 60000);
      end
      send_sample(SAMPLE_W'($urandom()), stim_time);
   endtask

   // Mostly well-formed pulses, some noise; re-roll the idle rate now and
   // then so stretches without idling occur too.
   task automatic run_mixed(input int n_items);
      int stop_at;
      int next_roll;
      stop_at   = sent_items + n_items;
      next_roll = sent_items;
      while (sent_items < stop_at) begin
         if (idle_on && sent_items >= next_roll) begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 10;
               default: idle_pct = 35;
            endcase
            next_roll = sent_items + 40;
         end
         if ($urandom_range(0, 99) < 80) begin
            send_pulse();
         end else begin
            send_noise();
         end
      end
   endtask

   // Hit each code on a window edge, the threshold and error level exactly,
   // close with and without a match while the alarm is up, and wrap time.
   task automatic test_directed();
      logic [TIME_W-1:0] t0;
      send_sample(0, 32'd5);
      send_sample(THRESHOLD_RST, 32'd6);
      stim_time = 32'd6;
      for (int k = 0; k < NUM_WINDOWS; k++) begin
         t0 = stim_time + 32'd20000;
         send_sample(k[0] ? SAMPLE_W'(SAMPLE_MAX) : THRESHOLD_RST + 1, t0);
         stim_time = t0 + WIDTH_OFFSET_US + (k[0] ? WINDOW_HIGH[k] - 1 : WINDOW_LOW[k] + 1);
         send_sample(k[0] ? ERROR_LEVEL_RST : THRESHOLD_RST, stim_time);
      end
      // width sits on a window edge: no match, closed under the alarm
      t0 = stim_time + 32'd20000;
      send_sample(SAMPLE_W'(SAMPLE_MAX), t0);
      stim_time = t0 + WIDTH_OFFSET_US + WINDOW_LOW[0];
      send_sample(0, stim_time);
      // matching close under the alarm: pattern wins over the forced high
      t0 = stim_time + 32'd20000;
      send_sample(SAMPLE_W'(SAMPLE_MAX), t0);
      stim_time = t0 + WIDTH_OFFSET_US + 32'd50000;
      send_sample(ERROR_LEVEL_RST - 1, stim_time);
      // pulse straddles the timestamp wrap
      t0 = 32'hFFFF_F000;
      send_sample(SAMPLE_W'(SAMPLE_MAX), t0);
      stim_time = t0 + WIDTH_OFFSET_US + 32'd100000;
      send_sample(THRESHOLD_RST, stim_time);
   endtask

   task automatic test_random_pulses();
      run_mixed(200);
   endtask

   task automatic test_config_sweep();
      apply_settings(SAMPLE_W'(SAMPLE_MAX), 0, RISE_DEBOUNCE_RST, FALL_DEBOUNCE_RST, 1'b1);
      run_mixed(55);
      apply_settings(0, SAMPLE_W'(SAMPLE_MAX), 0, 0, 1'b1);
      run_mixed(55);
      apply_settings(THRESHOLD_RST, ERROR_LEVEL_RST, 0, 0, 1'b1);
      run_mixed(55);
      apply_settings(THRESHOLD_RST, ERROR_LEVEL_RST, DEBOUNCE_MAX, DEBOUNCE_MAX, 1'b1);
      run_mixed(55);
      apply_settings(12'd3000, 12'd500, DEBOUNCE_MAX, 0, 1'b1);
      run_mixed(55);
      apply_settings(12'd1000, 12'd2000, 0, DEBOUNCE_MAX, 1'b1);
      run_mixed(55);
      repeat (2) begin
         apply_settings(SAMPLE_W'($urandom()), SAMPLE_W'($urandom_range(0, 1500)),
                        DEBOUNCE_W'($urandom_range(0, 40000)),
                        DEBOUNCE_W'($urandom_range(0, 40000)), 1'b1);
         run_mixed(55);
      end
   endtask

   task automatic test_decode_disabled();
      apply_settings(THRESHOLD_RST, ERROR_LEVEL_RST, RISE_DEBOUNCE_RST, FALL_DEBOUNCE_RST, 1'b0);
      run_mixed(60);
      apply_settings(THRESHOLD_RST, ERROR_LEVEL_RST, RISE_DEBOUNCE_RST, FALL_DEBOUNCE_RST, 1'b1);
   endtask

   task automatic test_timestamp_wrap();
      stim_time = 32'hFFFF_FFFF - $urandom_range(0, 300000);
      run_mixed(70);
   endtask

   // Final stretch: no idling on either side.
   task automatic test_back_to_back();
      wait_for_drain();
      idle_on  = 1'b0;
      idle_pct = 0;
      run_mixed(120);
   endtask

   // Receiver side: hold ready low for random bursts while idling is on.
   always @(negedge clock) begin
      if (idle_on && stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 99) < idle_pct) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      decode_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_decodes.size() == 0) begin
            report_mismatch("unexpected result, code", rsp_code, 0);
         end else begin
            want = expected_decodes.pop_front();
            if (rsp_alarm !== want.alarm) begin
               report_mismatch("alarm", rsp_alarm, want.alarm);
            end
            if (rsp_relay_humidifier !== want.humidifier) begin
               report_mismatch("relay_humidifier", rsp_relay_humidifier, want.humidifier);
            end
            if (rsp_relay_pump !== want.pump) begin
               report_mismatch("relay_pump", rsp_relay_pump, want.pump);
            end
            if (rsp_relay_fan !== want.fan) begin
               report_mismatch("relay_fan", rsp_relay_fan, want.fan);
            end
            if (rsp_code !== want.code) begin
               report_mismatch("code", rsp_code, want.code);
            end
            if (rsp_code_new !== want.code_new) begin
               report_mismatch("code_new", rsp_code_new, want.code_new);
            end
         end
         result_count++;
      end
   end

   initial begin
      // drive every input from time zero and hold reset
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_sample  = '0;
      req_time_us = '0;
      rsp_ready   = 1'b1;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      stall_left  = 0;
      idle_on     = 1'b1;
      idle_pct    = 20;
      stim_time   = '0;
      sent_items     = 0;
      result_count   = 0;
      mismatch_count = 0;
      // model starts from the reset state of the block
      cfg_threshold   = THRESHOLD_RST;
      cfg_error_level = ERROR_LEVEL_RST;
      cfg_rise        = RISE_DEBOUNCE_RST;
      cfg_fall        = FALL_DEBOUNCE_RST;
      cfg_decode_en   = 1'b1;
      last_high_us    = '0;
      pulse_start_us  = '0;
      pulse_done      = 1'b0;
      held_code       = CODE_NONE;
      relay_levels    = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_pulses();
      test_config_sweep();
      test_decode_disabled();
      test_timestamp_wrap();
      test_back_to_back();

      // drain, then give the block time to show any stray result
      wait_for_drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/pwcd_pkg.sv
rtl/core/pwcd_csr.sv
rtl/core/pwcd_track.sv
rtl/core/pulse_width_code_decoder_core.sv
dv/tb.sv
